>>> hw/rtl/mfp_pkg.sv
// Shared types, constants and CRC helper for the MAVLink v2 frame packer.
package mfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int MSGID_W  = 24;
    localparam int CFG_IDX_W = 1;
    localparam int HDR_IDX_W = 4;

    // Item operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_ID = 1'b1;

    localparam logic [15:0]       CRC_SEED     = 16'hFFFF;
    localparam logic [BYTE_W-1:0] MAGIC_V2     = 8'hFD;
    localparam logic [BYTE_W-1:0] SYSTEM_ID_RST    = 8'hFF;
    localparam logic [BYTE_W-1:0] COMPONENT_ID_RST = 8'd190;

    // Header byte positions after the magic byte
    localparam logic [HDR_IDX_W-1:0] HDR_LEN   = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_SEQ   = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_SYS   = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_COMP  = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_ID0   = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_ID1   = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_ID2   = 4'd9;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = 4'd9;

    // One request handed from the front to the back
    typedef struct packed {
        logic                is_start;
        logic                last;
        logic [BYTE_W-1:0]   data;
        logic [MSGID_W-1:0]  message_id;
        logic [BYTE_W-1:0]   sequence_number;
        logic [BYTE_W-1:0]   crc_extra_byte;
        logic [BYTE_W-1:0]   payload_length;
        logic [BYTE_W-1:0]   system_id;
        logic [BYTE_W-1:0]   component_id;
    } entry_t;

    // X.25 / MCRF4XX fold of one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
             ^ {12'h000, t[7:4]};
    endfunction

    // Header bytes one to nine; the flag bytes read as zero
    function automatic logic [BYTE_W-1:0] header_byte(input entry_t e,
                                                     input logic [HDR_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = '0;
        case (idx)
            HDR_LEN:  b = e.payload_length;
            HDR_SEQ:  b = e.sequence_number;
            HDR_SYS:  b = e.system_id;
            HDR_COMP: b = e.component_id;
            HDR_ID0:  b = e.message_id[7:0];
            HDR_ID1:  b = e.message_id[15:8];
            HDR_ID2:  b = e.message_id[23:16];
            default:  b = '0;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/mfp_in_if.sv
// Input item channel of the frame packer.
interface mfp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [mfp_pkg::MSGID_W-1:0]      message_id;
    logic [mfp_pkg::BYTE_W-1:0]       sequence_number;
    logic [mfp_pkg::BYTE_W-1:0]       crc_extra_byte;
    logic [mfp_pkg::BYTE_W-1:0]       payload_length;
    logic [mfp_pkg::BYTE_W-1:0]       payload_byte;

    modport source (output valid, operation, message_id, sequence_number,
                    crc_extra_byte, payload_length, payload_byte, input ready);
    modport sink   (input valid, operation, message_id, sequence_number,
                    crc_extra_byte, payload_length, payload_byte, output ready);
endinterface

>>> hw/rtl/mfp_out_if.sv
// Output byte channel of the frame packer.
interface mfp_out_if;
    logic                        valid;
    logic                        ready;
    logic [mfp_pkg::BYTE_W-1:0]  frame_byte;
    logic                        frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

>>> hw/rtl/mfp_cfg_if.sv
// Configuration write channel of the frame packer.
interface mfp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mfp_pkg::CFG_IDX_W-1:0]  index;
    logic [mfp_pkg::BYTE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/mfp_front.sv
// Front end: accepts items, tracks the open frame and queues requests.
module mfp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    mfp_in_if.sink                      items,
    input  logic [mfp_pkg::BYTE_W-1:0]  system_id,
    input  logic [mfp_pkg::BYTE_W-1:0]  component_id,
    output logic                        push_valid,
    input  logic                        push_ready,
    output mfp_pkg::entry_t             push_entry
);

    logic                        open_reg;
    logic                        open_next;
    logic [mfp_pkg::BYTE_W-1:0]  remaining_reg;
    logic [mfp_pkg::BYTE_W-1:0]  remaining_next;
    logic                        accept;
    logic                        is_start;

    assign items.ready = push_ready;

    always_comb
    begin
        accept   = items.valid && items.ready;
        is_start = (items.operation == mfp_pkg::OP_START);

        push_entry.is_start        = is_start;
        push_entry.last            = is_start ? (items.payload_length == '0)
                                              : (remaining_reg == 8'd1);
        push_entry.data            = items.payload_byte;
        push_entry.message_id      = items.message_id;
        push_entry.sequence_number = items.sequence_number;
        push_entry.crc_extra_byte  = items.crc_extra_byte;
        push_entry.payload_length  = items.payload_length;
        push_entry.system_id       = system_id;
        push_entry.component_id    = component_id;

        // drop payload bytes that arrive outside a frame
        push_valid = accept && (is_start || open_reg);

        open_next      = open_reg;
        remaining_next = remaining_reg;
        if (accept)
        begin
            if (is_start)
            begin
                open_next      = (items.payload_length != '0);
                remaining_next = items.payload_length;
            end
            else if (open_reg)
            begin
                open_next      = (remaining_reg != 8'd1);
                remaining_next = remaining_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            open_reg      <= open_next;
            remaining_reg <= remaining_next;
        end
    end

    a_open_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == (remaining_reg != '0))
        else $error("frame open flag disagrees with byte count");

endmodule

>>> hw/rtl/mfp_queue.sv
// Short request queue between front and back.
module mfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mfp_pkg::entry_t  push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mfp_pkg::entry_t  pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfp_pkg::entry_t   slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push_fire;
    logic              pop_fire;

    always_comb
    begin
        push_ready = (count_reg != CNT_W'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_entry  = slots_reg[rd_ptr_reg];
        push_fire  = push_valid && push_ready;
        pop_fire   = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = rd_ptr_reg;
        if (pop_fire)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

>>> hw/rtl/mfp_back.sv
// Back end: serializes header, payload and CRC bytes into the output register.
module mfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mfp_pkg::entry_t  pop_entry,
    mfp_out_if.source        frames
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_HDR    = 2'd1;
    localparam logic [1:0] S_CRC_LO = 2'd2;
    localparam logic [1:0] S_CRC_HI = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [mfp_pkg::HDR_IDX_W-1:0]    idx_reg;
    logic [mfp_pkg::HDR_IDX_W-1:0]    idx_next;
    logic [15:0]                      crc_reg;
    logic [15:0]                      crc_next;
    logic [15:0]                      crc_final;
    logic [mfp_pkg::BYTE_W-1:0]       extra_reg;
    logic [mfp_pkg::BYTE_W-1:0]       extra_next;
    mfp_pkg::entry_t                  hdr_reg;
    mfp_pkg::entry_t                  hdr_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [mfp_pkg::BYTE_W-1:0]       out_byte_reg;
    logic [mfp_pkg::BYTE_W-1:0]       out_byte_next;
    logic                             out_end_reg;
    logic                             out_end_next;
    logic                             adv;
    logic                             emit;

    assign frames.valid      = out_valid_reg;
    assign frames.frame_byte = out_byte_reg;
    assign frames.frame_end  = out_end_reg;

    always_comb
    begin
        adv       = !out_valid_reg || frames.ready;
        pop_ready = adv && (state_reg == S_IDLE);
        crc_final = mfp_pkg::crc_fold(crc_reg, extra_reg);

        state_next    = state_reg;
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        extra_next    = extra_reg;
        hdr_next      = hdr_reg;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        out_end_next  = out_end_reg;

        if (adv)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        emit = 1'b1;
                        out_end_next = 1'b0;
                        if (pop_entry.is_start)
                        begin
                            // new header abandons any unfinished frame
                            out_byte_next = mfp_pkg::MAGIC_V2;
                            crc_next      = mfp_pkg::CRC_SEED;
                            extra_next    = pop_entry.crc_extra_byte;
                            hdr_next      = pop_entry;
                            idx_next      = mfp_pkg::HDR_LEN;
                            state_next    = S_HDR;
                        end
                        else
                        begin
                            out_byte_next = pop_entry.data;
                            crc_next      = mfp_pkg::crc_fold(crc_reg, pop_entry.data);
                            if (pop_entry.last)
                                state_next = S_CRC_LO;
                        end
                    end
                end
                S_HDR:
                begin
                    emit          = 1'b1;
                    out_end_next  = 1'b0;
                    out_byte_next = mfp_pkg::header_byte(hdr_reg, idx_reg);
                    crc_next      = mfp_pkg::crc_fold(crc_reg, out_byte_next);
                    idx_next      = idx_reg + 1'b1;
                    if (idx_reg == mfp_pkg::HDR_LAST)
                        state_next = hdr_reg.last ? S_CRC_LO : S_IDLE;
                end
                S_CRC_LO:
                begin
                    emit          = 1'b1;
                    out_end_next  = 1'b0;
                    out_byte_next = crc_final[7:0];
                    crc_next      = crc_final;
                    state_next    = S_CRC_HI;
                end
                S_CRC_HI:
                begin
                    emit          = 1'b1;
                    out_end_next  = 1'b1;
                    out_byte_next = crc_reg[15:8];
                    state_next    = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end

        out_valid_next = emit ? 1'b1 : (out_valid_reg && !frames.ready);
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        extra_reg    <= extra_next;
        hdr_reg      <= hdr_next;
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= mfp_pkg::HDR_LEN;
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_end_reg   <= out_end_next;
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |-> state_reg == S_IDLE)
        else $error("request taken while a frame step is pending");

    a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HDR |-> idx_reg >= mfp_pkg::HDR_LEN && idx_reg <= mfp_pkg::HDR_LAST)
        else $error("header index out of range");

    a_end_after_crc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_end_reg) |-> $past(state_reg == S_CRC_HI))
        else $error("frame end raised outside the high CRC step");

endmodule

>>> hw/rtl/mavlink2_frame_packer_unit.sv
// Top level of the MAVLink v2 frame packer.
// Usage:
//   items  : request channel. operation 0 opens a frame with message_id,
//            sequence_number, crc_extra_byte and payload_length; operation 1
//            carries one payload_byte. Payload outside a frame is taken and dropped.
//   frames : byte stream, frame_end marks the high CRC byte of each frame.
//   cfg    : register writes (index 0 system id, index 1 component id), always ready.
// Timing: an accepted request enters the queue at once; its first byte passes
//   from the queue slot through the output register to frames. A start request
//   yields ten header bytes (then the two CRC bytes with a zero length), a payload byte
//   one byte, the last payload byte also the two CRC bytes. The back end serializer sets
//   the rate: one byte, so one payload request, per cycle while frames.ready is high.
// Stall: when frames.ready is low the output register holds its byte, the
//   back end stops, and items.ready falls once the QUEUE_DEPTH-entry queue fills.
// Reset: clears the queue, frame state and output valid; system id reads 255 and
//   component id 190.
module mavlink2_frame_packer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    mfp_in_if.sink    items,
    mfp_out_if.source frames,
    mfp_cfg_if.sink   cfg
);

    logic [mfp_pkg::BYTE_W-1:0]  system_id_reg;
    logic [mfp_pkg::BYTE_W-1:0]  component_id_reg;
    logic                        push_valid;
    logic                        push_ready;
    mfp_pkg::entry_t             push_entry;
    logic                        pop_valid;
    logic                        pop_ready;
    mfp_pkg::entry_t             pop_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system_id_reg    <= mfp_pkg::SYSTEM_ID_RST;
            component_id_reg <= mfp_pkg::COMPONENT_ID_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                mfp_pkg::REG_SYSTEM_ID:    system_id_reg    <= cfg.data;
                mfp_pkg::REG_COMPONENT_ID: component_id_reg <= cfg.data;
                default:                   system_id_reg    <= system_id_reg;
            endcase
        end
    end

    mfp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .system_id    (system_id_reg),
        .component_id (component_id_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    mfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .frames    (frames)
    );

endmodule
